[rtl/beacon_lamp_edge_scanner_top_defines.svh]
// ----------------------------------------------------------------------------
// Beacon lamp edge scanner - assertion macros
// Shared concurrent assertion forms, clocked on clock and off during reset.
// ----------------------------------------------------------------------------
`ifndef BEACON_LAMP_EDGE_SCANNER_TOP_DEFINES_SVH
`define BEACON_LAMP_EDGE_SCANNER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define BLES_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bles: same-cycle check failed");

// Consequent checked in the cycle after the antecedent
`define BLES_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bles: next-cycle check failed");

`endif

[rtl/bles_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon lamp edge scanner - package
// Widths, frame geometry, register indexes and the item types passed between
// the front, the queue and the back.
// ----------------------------------------------------------------------------
package bles_pkg;

   // Frame geometry
   localparam int IMAGE_COLS = 188;
   localparam int IMAGE_ROWS = 120;

   // Field widths
   localparam int ROW_W  = 7;
   localparam int COL_W  = 8;
   localparam int PIX_W  = 8;
   localparam int COEF_W = 32;
   localparam int FRAC_W = 16;

   // Curve arithmetic widths
   localparam int SQ_W    = 2 * COL_W;
   localparam int PA_W    = COEF_W + SQ_W + 1;
   localparam int PB_W    = COEF_W + COL_W + 1;
   localparam int CURVE_W = PA_W + 1;

   // Column where the row limit of the curve is taken
   localparam logic [COL_W-1:0] MID_COL = COL_W'(IMAGE_COLS / 2);
   localparam logic [SQ_W-1:0]  MID_SQ  = SQ_W'((IMAGE_COLS / 2) * (IMAGE_COLS / 2));

   // Stream widths
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   // Decoupling queue
   localparam int QUEUE_DEPTH = 4;

   // Control and status registers
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_CURVE_A   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CURVE_B   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CURVE_C   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHT_TH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM_TH    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SPLIT_ROW = 3'd5;

   localparam logic [PIX_W-1:0] BRIGHT_RESET = 8'd200;
   localparam logic [PIX_W-1:0] DIM_RESET    = 8'd50;
   localparam logic [ROW_W-1:0] SPLIT_RESET  = 7'd50;

   typedef struct packed {
      logic signed [COEF_W-1:0] curve_a;
      logic signed [COEF_W-1:0] curve_b;
      logic signed [COEF_W-1:0] curve_c;
      logic [PIX_W-1:0]         bright_threshold;
      logic [PIX_W-1:0]         dim_threshold;
      logic [ROW_W-1:0]         split_row;
   } cfg_type;

   // Pixel as accepted from the stream
   typedef struct packed {
      logic             frame_start;
      logic             last_in_frame;
      logic [ROW_W-1:0] pixel_row;
      logic [COL_W-1:0] pixel_col;
      logic [PIX_W-1:0] left_pixel;
      logic [PIX_W-1:0] center_pixel;
      logic [PIX_W-1:0] right_pixel;
   } pix_type;

   // Pixel after classification, as held in the queue
   typedef struct packed {
      logic             frame_start;
      logic             last_in_frame;
      logic [ROW_W-1:0] pixel_row;
      logic [COL_W-1:0] pixel_col;
      logic             in_range;      // inside frame and over the row limit
      logic             upper;         // row above split
      logic             lower;         // row below split
      logic             left_dark;
      logic             centre_bright;
      logic             right_dark;
      logic             centre_dim;    // centre over dim threshold
      logic             above_curve;   // row above curve at own column
   } cls_type;

endpackage

[rtl/beacon_lamp_edge_scanner_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon lamp edge scanner - top level
// Pixel stream in, at most one beacon position per frame out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel per transfer with its row, column and both
//   neighbours; req_tuser marks the frame start, req_tlast the final pixel.
//   rsp_* carries one result per frame: rsp_tuser is high when a beacon was
//   found, and x and y are zero when it was not.
//   csr_* writes the curve coefficients, thresholds and split row and is always
//   ready; the user writes it only while no pixel is in flight (not enforced).
// Timing:
//   One pixel per cycle is sustained unless the queue is full. A pixel passes
//   three front stages for the column square, the curve products and the
//   curve sums, then the queue and the output register of the back.
// Reset and stalls:
//   Reset restores the register defaults and clears the scan state. While
//   rsp_tready is low the result is held; the queue then fills and req_tready
//   drops once the last front stage cannot hand its pixel over.
// ----------------------------------------------------------------------------
module beacon_lamp_edge_scanner_top #(
   parameter int QUEUE_DEPTH = bles_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Pixel stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [6:0] pixel_row, [14:7] pixel_col, [22:15] left_pixel,
   // [30:23] center_pixel, [38:31] right_pixel, [39] zero
   input  logic [bles_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                  req_tlast,   // last_in_frame
   input  logic                                  req_tuser,   // frame_start
   // Result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] beacon_x, [14:8] beacon_y, [15] zero
   output logic [bles_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tuser,   // beacon_found
   // Register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bles_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bles_pkg::COEF_W-1:0]           csr_data
);
   import bles_pkg::*;

   cfg_type cfg_ff, cfg_in;
   pix_type req_item;
   cls_type push_item;
   cls_type pop_item;
   logic    push_valid;
   logic    q_full;
   logic    q_not_empty;
   logic    pop;

   assign csr_ready = 1'b1;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_CURVE_A:   cfg_in.curve_a          = csr_data;
            REG_CURVE_B:   cfg_in.curve_b          = csr_data;
            REG_CURVE_C:   cfg_in.curve_c          = csr_data;
            REG_BRIGHT_TH: cfg_in.bright_threshold = csr_data[PIX_W-1:0];
            REG_DIM_TH:    cfg_in.dim_threshold    = csr_data[PIX_W-1:0];
            REG_SPLIT_ROW: cfg_in.split_row        = csr_data[ROW_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curve_a          <= '0;
         cfg_ff.curve_b          <= '0;
         cfg_ff.curve_c          <= '0;
         cfg_ff.bright_threshold <= BRIGHT_RESET;
         cfg_ff.dim_threshold    <= DIM_RESET;
         cfg_ff.split_row        <= SPLIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the pixel transfer
   always_comb begin
      req_item.frame_start   = req_tuser;
      req_item.last_in_frame = req_tlast;
      req_item.pixel_row     = req_tdata[6:0];
      req_item.pixel_col     = req_tdata[14:7];
      req_item.left_pixel    = req_tdata[22:15];
      req_item.center_pixel  = req_tdata[30:23];
      req_item.right_pixel   = req_tdata[38:31];
   end

   bles_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   bles_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_item  (pop_item)
   );

   bles_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_item     (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/bles_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon lamp edge scanner - front
// Three-stage pipeline that evaluates the ceiling curve at the pixel column
// and at the centre column, then classifies the pixel into the queue.
// ----------------------------------------------------------------------------
module bles_front (
   input  logic              clock,
   input  logic              reset,
   input  bles_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  bles_pkg::pix_type in_item,
   input  logic              q_full,
   output logic              push_valid,
   output bles_pkg::cls_type push_item
);
   import bles_pkg::*;

   logic signed [COEF_W-1:0] coef_a;
   logic signed [COEF_W-1:0] coef_b;
   logic signed [COEF_W-1:0] coef_c;
   logic                     advance;

   // Stage A: square of the column
   logic            a_valid_ff;
   pix_type         a_item_ff;
   logic [SQ_W-1:0] a_sq_ff;
   logic [SQ_W-1:0] a_sq_in;

   // Stage B: products
   logic                   b_valid_ff;
   pix_type                b_item_ff;
   logic signed [PA_W-1:0] b_pa_col_ff, b_pa_col_in;
   logic signed [PA_W-1:0] b_pa_mid_ff, b_pa_mid_in;
   logic signed [PB_W-1:0] b_pb_col_ff, b_pb_col_in;
   logic signed [PB_W-1:0] b_pb_mid_ff, b_pb_mid_in;

   // Stage C: curve values
   logic                      c_valid_ff;
   pix_type                   c_item_ff;
   logic signed [CURVE_W-1:0] c_curve_col_ff, c_curve_col_in;
   logic signed [CURVE_W-1:0] c_curve_mid_ff, c_curve_mid_in;
   logic signed [CURVE_W-1:0] row_scaled;

   assign coef_a = cfg.curve_a;
   assign coef_b = cfg.curve_b;
   assign coef_c = cfg.curve_c;

   // Whole pipe moves unless the last stage is blocked by a full queue
   assign advance    = !(c_valid_ff && q_full);
   assign in_ready   = advance;
   assign push_valid = c_valid_ff && !q_full;

   // Datapath arithmetic
   always_comb begin
      a_sq_in        = SQ_W'(in_item.pixel_col) * SQ_W'(in_item.pixel_col);
      b_pa_col_in    = coef_a * $signed({1'b0, a_sq_ff});
      b_pa_mid_in    = coef_a * $signed({1'b0, MID_SQ});
      b_pb_col_in    = coef_b * $signed({1'b0, a_item_ff.pixel_col});
      b_pb_mid_in    = coef_b * $signed({1'b0, MID_COL});
      c_curve_col_in = CURVE_W'(b_pa_col_ff) - CURVE_W'(b_pb_col_ff) + CURVE_W'(coef_c);
      c_curve_mid_in = CURVE_W'(b_pa_mid_ff) - CURVE_W'(b_pb_mid_ff) + CURVE_W'(coef_c);
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         a_item_ff      <= in_item;
         a_sq_ff        <= a_sq_in;
         b_item_ff      <= a_item_ff;
         b_pa_col_ff    <= b_pa_col_in;
         b_pa_mid_ff    <= b_pa_mid_in;
         b_pb_col_ff    <= b_pb_col_in;
         b_pb_mid_ff    <= b_pb_mid_in;
         c_item_ff      <= b_item_ff;
         c_curve_col_ff <= c_curve_col_in;
         c_curve_mid_ff <= c_curve_mid_in;
      end
   end

   // Classification of the pixel leaving stage C
   assign row_scaled = $signed(CURVE_W'({c_item_ff.pixel_row, {FRAC_W{1'b0}}}));

   always_comb begin
      push_item.frame_start   = c_item_ff.frame_start;
      push_item.last_in_frame = c_item_ff.last_in_frame;
      push_item.pixel_row     = c_item_ff.pixel_row;
      push_item.pixel_col     = c_item_ff.pixel_col;
      push_item.in_range      = (c_item_ff.pixel_col != '0)
                             && (int'(c_item_ff.pixel_col) < IMAGE_COLS)
                             && (int'(c_item_ff.pixel_row) <= IMAGE_ROWS - 2)
                             && (row_scaled > c_curve_mid_ff);
      push_item.upper         = c_item_ff.pixel_row > cfg.split_row;
      push_item.lower         = c_item_ff.pixel_row < cfg.split_row;
      push_item.left_dark     = c_item_ff.left_pixel < cfg.bright_threshold;
      push_item.centre_bright = c_item_ff.center_pixel > cfg.bright_threshold;
      push_item.right_dark    = c_item_ff.right_pixel < cfg.bright_threshold;
      push_item.centre_dim    = c_item_ff.center_pixel > cfg.dim_threshold;
      push_item.above_curve   = row_scaled > c_curve_col_ff;
   end

endmodule

[rtl/bles_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon lamp edge scanner - queue
// Small FIFO of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module bles_queue #(
   parameter int DEPTH = bles_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bles_pkg::cls_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output bles_pkg::cls_type pop_item
);
   import bles_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cls_type           store [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_item  = store[rd_ptr_ff];

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/bles_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon lamp edge scanner - back
// Applies the lamp and beacon rules to classified pixels, keeps the scan
// state and holds the result in the output register.
// ----------------------------------------------------------------------------
module bles_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  bles_pkg::cls_type q_item,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              rsp_tuser,
   output logic [bles_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import bles_pkg::*;
   `include "beacon_lamp_edge_scanner_top_defines.svh"

   // Scan state
   logic             lamp_open_ff, lamp_open_in;
   logic [COL_W-1:0] left_edge_column_ff, left_edge_column_in;
   logic [ROW_W-1:0] lamp_row_ff, lamp_row_in;
   logic             scan_finished_ff, scan_finished_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [COL_W-1:0] rsp_x_ff, rsp_x_in;
   logic [ROW_W-1:0] rsp_y_ff, rsp_y_in;

   // Rule evaluation
   logic             fin_now;
   logic             open_now;
   logic [COL_W-1:0] edge_now;
   logic [ROW_W-1:0] row_now;
   logic             active;
   logic             open_hit;
   logic             lamp_after;
   logic [COL_W-1:0] edge_after;
   logic [ROW_W-1:0] row_after;
   logic             close_hit;
   logic             curve_hit;
   logic             end_hit;
   logic             emit;
   logic [COL_W:0]   mid_sum;

   assign pop = q_valid && (!rsp_valid_ff || rsp_tready);

   // Rules in priority order, frame start clearing first
   always_comb begin
      fin_now    = scan_finished_ff && !q_item.frame_start;
      open_now   = lamp_open_ff && !q_item.frame_start;
      edge_now   = q_item.frame_start ? '0 : left_edge_column_ff;
      row_now    = q_item.frame_start ? '0 : lamp_row_ff;
      active     = !fin_now && q_item.in_range;
      open_hit   = active && q_item.upper && !open_now
                && q_item.left_dark && q_item.centre_bright;
      lamp_after = open_now || open_hit;
      edge_after = open_hit ? q_item.pixel_col : edge_now;
      row_after  = open_hit ? q_item.pixel_row : row_now;
      close_hit  = active && q_item.upper && lamp_after
                && q_item.centre_bright && q_item.right_dark;
      curve_hit  = active && !close_hit && q_item.lower && !lamp_after
                && q_item.centre_dim && q_item.above_curve;
      end_hit    = q_item.last_in_frame && !fin_now && !close_hit && !curve_hit;
      emit       = close_hit || curve_hit || end_hit;
      mid_sum    = {1'b0, edge_after} + {1'b0, q_item.pixel_col};
   end

   // Next state and output register
   always_comb begin
      lamp_open_in        = lamp_open_ff;
      left_edge_column_in = left_edge_column_ff;
      lamp_row_in         = lamp_row_ff;
      scan_finished_in    = scan_finished_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_tready;
      rsp_found_in        = rsp_found_ff;
      rsp_x_in            = rsp_x_ff;
      rsp_y_in            = rsp_y_ff;
      if (pop) begin
         lamp_open_in        = lamp_after;
         left_edge_column_in = edge_after;
         lamp_row_in         = row_after;
         scan_finished_in    = fin_now || emit;
         if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = close_hit || curve_hit;
            if (close_hit) begin
               rsp_x_in = mid_sum[COL_W:1];
               rsp_y_in = row_after;
            end else if (curve_hit) begin
               rsp_x_in = q_item.pixel_col;
               rsp_y_in = q_item.pixel_row;
            end else begin
               rsp_x_in = '0;
               rsp_y_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_open_ff        <= 1'b0;
         left_edge_column_ff <= '0;
         lamp_row_ff         <= '0;
         scan_finished_ff    <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         lamp_open_ff        <= lamp_open_in;
         left_edge_column_ff <= left_edge_column_in;
         lamp_row_ff         <= lamp_row_in;
         scan_finished_ff    <= scan_finished_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_y_ff, rsp_x_ff});

   // A finished scan stays finished until a frame start is consumed
   `BLES_ASSERT_NEXT(a_finished_holds, scan_finished_ff && !(pop && q_item.frame_start), scan_finished_ff)
   // Every result ends the scan and lands in the output register
   `BLES_ASSERT_NEXT(a_result_ends_scan, pop && emit, scan_finished_ff && rsp_valid_ff)
   // A not-found result carries zero coordinates
   `BLES_ASSERT_NOW(a_not_found_zero, rsp_valid_ff && !rsp_found_ff, rsp_x_ff == '0 && rsp_y_ff == '0)

endmodule

[test/tb_beacon_lamp_edge_scanner_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beacon lamp edge scanner - testbench
// Drives pixel frames into the scanner and checks every beacon result against
// a typed value or a cycle-free software scanner fed the accepted transfers.
// A short table of hand-picked pixels runs first under the register defaults.
// Random frames follow under several register settings, the extremes among
// them, with random gaps and result back-pressure but in one quiet phase.
// ----------------------------------------------------------------------------
module tb_beacon_lamp_edge_scanner_top;
   import bles_pkg::*;

   localparam int PLAN_LEN     = 24;
   localparam int N_PHASES     = 8;
   localparam int PHASE_ITEMS  = 250;
   localparam int PHASE_FRAMES = 150;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic       found;
      logic [7:0] x;
      logic [6:0] y;
   } beacon_type;

   // One hand-picked pixel; the result is typed in when checked is set
   typedef struct packed {
      logic       fs;
      logic       eof;
      logic [6:0] row;
      logic [7:0] col;
      logic [7:0] lp;
      logic [7:0] cp;
      logic [7:0] rp;
      logic       checked;
      logic       found;
      logic [7:0] x;
      logic [6:0] y;
   } plan_row_type;

   // Register defaults: curve all zero, bright 200, dim 50, split 50
   plan_row_type directed_plan [PLAN_LEN] = '{
      // row 0 never lies above a zero curve, so only the frame end answers
      '{1, 1,   0,  94, 255, 255,   0, 1, 0,   0,   0},
      // lower-region beacon just over the dim level
      '{1, 1,  10,   1,   0,  51,   0, 1, 1,   1,  10},
      '{1, 1,  10,   5,   0,  50,   0, 1, 0,   0,   0},
      // lamp opens at column 20, stays lit, closes at column 41
      '{1, 0,  60,  20, 199, 201, 201, 0, 0,   0,   0},
      '{0, 0,  61,  30,   0, 255, 255, 0, 0,   0,   0},
      '{0, 1,  60,  41, 255, 201, 199, 1, 1,  30,  60},
      // ignored once the scan has answered
      '{0, 1,  70,  50,   0, 255,   0, 0, 0,   0,   0},
      // lamp opening and closing on one pixel
      '{1, 0,  70, 100,   0, 255,   0, 1, 1, 100,  70},
      // row on the split, columns and rows out of range
      '{1, 0,  50,  10,   0, 255,   0, 0, 0,   0,   0},
      '{0, 0,  80,   0,   0, 255,   0, 0, 0,   0,   0},
      '{0, 0,  80, 188,   0, 255,   0, 0, 0,   0,   0},
      '{0, 0,  80, 255,   0, 255,   0, 0, 0,   0,   0},
      '{0, 0, 119,  60,   0, 255,   0, 0, 0,   0,   0},
      '{0, 1,  30,  60,   0,   0,   0, 1, 0,   0,   0},
      // lamp left open blocks the lower rule up to the frame end
      '{1, 0,  90,  30,   0, 255, 255, 0, 0,   0,   0},
      '{0, 0,  20,  30,   0, 255,   0, 0, 0,   0,   0},
      '{0, 1,  21,  31, 255, 255, 255, 1, 0,   0,   0},
      // field extremes
      '{1, 1, 118, 187,   0, 255,   0, 1, 1, 187, 118},
      '{1, 1,  49, 187, 255, 255, 255, 1, 1, 187,  49},
      '{1, 1,   1,   1,   0,   0,   0, 1, 0,   0,   0},
      // levels equal to the bright threshold cross nothing
      '{1, 0, 100, 150, 200, 255,   0, 0, 0,   0,   0},
      '{0, 0, 100, 151,   0, 200,   0, 0, 0,   0,   0},
      // an ignored pixel still ends the frame
      '{0, 1, 119, 152,   0, 255,   0, 1, 0,   0,   0},
      // no frame start after the answer: ignored
      '{0, 0,  40,  40,   0, 255,   0, 0, 0,   0,   0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tlast;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0]      csr_data = '0;

   // Pixel on the request bus and the typed result that goes with it
   pix_type    drv_pix    = '0;
   logic       drv_typed  = 1'b0;
   beacon_type drv_beacon = '0;

   // Scanner mirror: registers and per-frame state
   cfg_type    cfg_shadow;
   logic       lamp_open;
   logic [7:0] lamp_col;
   logic [6:0] lamp_row;
   logic       scan_done;

   beacon_type pending_beacons [$];
   int         fault_count = 0;
   int         sent_count = 0;
   bit         quiet = 1'b0;

   assign req_tdata = {1'b0, drv_pix.right_pixel, drv_pix.center_pixel, drv_pix.left_pixel,
                       drv_pix.pixel_col, drv_pix.pixel_row};
   assign req_tuser = drv_pix.frame_start;
   assign req_tlast = drv_pix.last_in_frame;

   beacon_lamp_edge_scanner_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Result back-pressure
   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 8);
   end

   // Row strictly above the Q16.16 ceiling curve at a column
   function automatic bit above_ceiling(logic [6:0] row, logic [7:0] col);
      longint x;
      longint ceiling;
      x = longint'(col);
      ceiling = longint'($signed(cfg_shadow.curve_a)) * x * x
              - longint'($signed(cfg_shadow.curve_b)) * x
              + longint'($signed(cfg_shadow.curve_c));
      return longint'(row) * 65536 > ceiling;
   endfunction

   // Advance the mirror by one pixel; returns 1 when a result is due
   function automatic bit scan_pixel(input pix_type p, output beacon_type res);
      bit active;
      bit upper;
      res = '0;
      if (p.frame_start) begin
         lamp_open = 1'b0;
         lamp_col  = '0;
         lamp_row  = '0;
         scan_done = 1'b0;
      end
      active = !scan_done && p.pixel_col >= 1 && p.pixel_col < IMAGE_COLS
            && p.pixel_row <= IMAGE_ROWS - 2 && above_ceiling(p.pixel_row, MID_COL);
      upper = p.pixel_row > cfg_shadow.split_row;
      if (active) begin
         // rising crossing opens the lamp
         if (upper && !lamp_open && p.left_pixel < cfg_shadow.bright_threshold
             && p.center_pixel > cfg_shadow.bright_threshold) begin
            lamp_open = 1'b1;
            lamp_col  = p.pixel_col;
            lamp_row  = p.pixel_row;
         end
         // falling crossing closes it, midpoint rounded down
         if (upper && lamp_open && p.center_pixel > cfg_shadow.bright_threshold
             && p.right_pixel < cfg_shadow.bright_threshold) begin
            scan_done = 1'b1;
            res.found = 1'b1;
            res.x     = 8'((int'(lamp_col) + int'(p.pixel_col)) >> 1);
            res.y     = lamp_row;
            return 1'b1;
         end
         // single dim pixel above the curve
         if (p.pixel_row < cfg_shadow.split_row && !lamp_open
             && p.center_pixel > cfg_shadow.dim_threshold
             && above_ceiling(p.pixel_row, p.pixel_col)) begin
            scan_done = 1'b1;
            res.found = 1'b1;
            res.x     = p.pixel_col;
            res.y     = p.pixel_row;
            return 1'b1;
         end
      end
      // frame end with nothing found
      if (p.last_in_frame && !scan_done) begin
         scan_done = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Register writes, accepted pixels and results, all seen at the rising edge
   always @(posedge clock) begin
      pix_type    seen;
      beacon_type calc;
      beacon_type got;
      beacon_type want;
      bit         emits;
      if (reset) begin
         cfg_shadow.curve_a          = '0;
         cfg_shadow.curve_b          = '0;
         cfg_shadow.curve_c          = '0;
         cfg_shadow.bright_threshold = BRIGHT_RESET;
         cfg_shadow.dim_threshold    = DIM_RESET;
         cfg_shadow.split_row        = SPLIT_RESET;
         lamp_open = 1'b0;
         lamp_col  = '0;
         lamp_row  = '0;
         scan_done = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CURVE_A:   cfg_shadow.curve_a = csr_data;
               REG_CURVE_B:   cfg_shadow.curve_b = csr_data;
               REG_CURVE_C:   cfg_shadow.curve_c = csr_data;
               REG_BRIGHT_TH: cfg_shadow.bright_threshold = csr_data[7:0];
               REG_DIM_TH:    cfg_shadow.dim_threshold = csr_data[7:0];
               REG_SPLIT_ROW: cfg_shadow.split_row = csr_data[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            seen.frame_start   = req_tuser;
            seen.last_in_frame = req_tlast;
            seen.pixel_row     = req_tdata[6:0];
            seen.pixel_col     = req_tdata[14:7];
            seen.left_pixel    = req_tdata[22:15];
            seen.center_pixel  = req_tdata[30:23];
            seen.right_pixel   = req_tdata[38:31];
            emits = scan_pixel(seen, calc);
            sent_count++;
            if (drv_typed) pending_beacons.push_back(drv_beacon);
            else if (emits) pending_beacons.push_back(calc);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.found = rsp_tuser;
            got.x     = rsp_tdata[7:0];
            got.y     = rsp_tdata[14:8];
            if (pending_beacons.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected result, expected none, got found %0d x %0d y %0d",
                        $time, got.found, got.x, got.y);
            end else begin
               want = pending_beacons.pop_front();
               if (got.found !== want.found) begin
                  fault_count++;
                  $display("%0t: beacon_found expected %0d got %0d", $time, want.found, got.found);
               end
               if (got.x !== want.x) begin
                  fault_count++;
                  $display("%0t: beacon_x expected %0d got %0d", $time, want.x, got.x);
               end
               if (got.y !== want.y) begin
                  fault_count++;
                  $display("%0t: beacon_y expected %0d got %0d", $time, want.y, got.y);
               end
            end
         end
      end
   end

   // One pixel transfer, with an occasional gap in front of it
   task automatic send_pixel(input pix_type p, input bit typed, input beacon_type b);
      while (!quiet && $urandom_range(0, 99) < 8) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      drv_pix    <= p;
      drv_typed  <= typed;
      drv_beacon <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and let every result and in-flight pixel drain
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_beacons.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr_valid is left high; the caller drops it after the batch
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [COEF_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input int a, input int b, input int c,
                                 input int bright, input int dim, input int split);
      write_reg(REG_CURVE_A, 32'(a));
      write_reg(REG_CURVE_B, 32'(b));
      write_reg(REG_CURVE_C, 32'(c));
      write_reg(REG_BRIGHT_TH, 32'(bright & 8'hff));
      write_reg(REG_DIM_TH, 32'(dim & 8'hff));
      write_reg(REG_SPLIT_ROW, 32'(split & 7'h7f));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Grey level on the chosen side of a threshold, sometimes on it or anywhere
   function automatic logic [7:0] gray_near(bit hi, logic [7:0] th);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return th;
      if (pick == 1) return 8'($urandom_range(0, 255));
      if (hi) return (th == 8'd255) ? th : 8'($urandom_range(int'(th) + 1, 255));
      return (th == 8'd0) ? th : 8'($urandom_range(0, int'(th) - 1));
   endfunction

   // Mostly lamp rows or beacon rows, a few on the split or anywhere
   function automatic logic [6:0] pick_row();
      int sp;
      int pick;
      sp = cfg_shadow.split_row;
      pick = $urandom_range(0, 99);
      if (pick < 50 && sp < IMAGE_ROWS - 2) return 7'($urandom_range(sp + 1, IMAGE_ROWS - 2));
      if (pick < 80 && sp > 0) return 7'($urandom_range(0, sp - 1));
      if (pick < 85) return 7'(sp);
      return 7'($urandom_range(0, IMAGE_ROWS - 1));
   endfunction

   // One frame: a few runs along rows with a consistent brightness profile
   task automatic send_frame();
      int         segs;
      int         n;
      int         first_col;
      bit         with_start;
      bit         with_end;
      bit         hi;
      logic [6:0] row;
      logic [7:0] th;
      logic [7:0] lvl [0:9];
      pix_type    p;
      beacon_type none;
      none = '0;
      with_start = ($urandom_range(0, 9) != 0);
      with_end   = ($urandom_range(0, 9) != 0);
      segs = $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
         n   = $urandom_range(1, 8);
         row = pick_row();
         th  = (row > cfg_shadow.split_row) ? cfg_shadow.bright_threshold
                                           : cfg_shadow.dim_threshold;
         hi  = $urandom_range(0, 1);
         for (int i = 0; i < n + 2; i++) begin
            if ($urandom_range(0, 99) < 35) hi = !hi;
            lvl[i] = gray_near(hi, th);
         end
         first_col = $urandom_range(1, IMAGE_COLS - n);
         for (int i = 0; i < n; i++) begin
            p.frame_start   = with_start && s == 0 && i == 0;
            p.last_in_frame = with_end && s == segs - 1 && i == n - 1;
            p.pixel_row     = row;
            p.pixel_col     = 8'(first_col + i);
            p.left_pixel    = lvl[i];
            p.center_pixel  = lvl[i + 1];
            // dark past the right edge
            p.right_pixel   = (first_col + i == IMAGE_COLS - 1) ? 8'd0 : lvl[i + 2];
            // odd stray pixel with arbitrary fields and flags
            if ($urandom_range(0, 99) < 3) begin
               p.frame_start   = $urandom_range(0, 1);
               p.last_in_frame = $urandom_range(0, 1);
               p.pixel_row     = 7'($urandom_range(0, IMAGE_ROWS - 1));
               p.pixel_col     = 8'($urandom_range(1, IMAGE_COLS - 1));
               p.left_pixel    = 8'($urandom_range(0, 255));
               p.center_pixel  = 8'($urandom_range(0, 255));
               p.right_pixel   = 8'($urandom_range(0, 255));
            end
            send_pixel(p, 1'b0, none);
         end
      end
   endtask

   // Run watchdog
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      pix_type    p;
      beacon_type b;
      int         base;
      int         frames;
      int         a;
      int         bc;
      int         c;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table under the register defaults
      for (int i = 0; i < PLAN_LEN; i++) begin
         p.frame_start   = directed_plan[i].fs;
         p.last_in_frame = directed_plan[i].eof;
         p.pixel_row     = directed_plan[i].row;
         p.pixel_col     = directed_plan[i].col;
         p.left_pixel    = directed_plan[i].lp;
         p.center_pixel  = directed_plan[i].cp;
         p.right_pixel   = directed_plan[i].rp;
         b.found = directed_plan[i].found;
         b.x     = directed_plan[i].x;
         b.y     = directed_plan[i].y;
         send_pixel(p, directed_plan[i].checked, b);
      end
      drain();

      // Random frames, one register setting per phase
      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            // parabola sitting ten rows up at the centre column
            0: apply_settings(655, 123207, 6446121, 200, 50, 50);
            1: apply_settings(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 255, 119);
            2: apply_settings(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 255, 0, 0);
            7: apply_settings(0, 0, 0, BRIGHT_RESET, DIM_RESET, SPLIT_RESET);
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  a  = $urandom;
                  bc = $urandom;
                  c  = $urandom;
               end else begin
                  a  = int'($urandom_range(0, 1400)) - 300;
                  bc = int'($urandom_range(0, 260000)) - 30000;
                  c  = int'($urandom_range(0, 110 * 65536));
               end
               apply_settings(a, bc, c, $urandom_range(60, 250), $urandom_range(0, 255),
                              $urandom_range(0, IMAGE_ROWS - 1));
            end
         endcase
         quiet  = (ph == 3);
         base   = sent_count;
         frames = 0;
         while (sent_count - base < PHASE_ITEMS && frames < PHASE_FRAMES) begin
            send_frame();
            frames++;
         end
         drain();
         quiet = 1'b0;
      end

      if (fault_count == 0 && pending_beacons.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
